// File: sv/lfps_pkg.sv
// lfps_pkg: shared types, codes and constants for the line follower steering block.
// Used by lfps_ctrl, lfps_dp and line_follow_pid_steering. No dependencies.
package lfps_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int THRESH_BITS     = 10;
    localparam int LOST_TIMEOUT_MS = 5000;
    localparam int SEARCH_FLIP_MS  = 1000;
    localparam int SEARCH_SPEED    = 150;
    localparam int MIN_BASE_SPEED  = 50;
    localparam int DIV_STEPS       = 16;   // quotient bits (|error| <= 25600)
    localparam int OUT_BITS        = 40;   // 35 field bits, padded to bytes

    typedef enum logic [3:0] {
        ST_IDLE, ST_SUM, ST_CHECK, ST_DIV, ST_INTEG,
        ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DRIVE, ST_LOST, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        REG_THRESH, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D,
        REG_LIMIT_HI, REG_LIMIT_LO, REG_CRUISE, REG_MAX_DRIVE
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_FOLLOW, MODE_ROT_RIGHT, MODE_ROT_LEFT, MODE_STOP
    } drive_mode_t;

    typedef enum logic [1:0] {
        MSEL_P, MSEL_I, MSEL_D, MSEL_NONE
    } mul_sel_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] detect_threshold;
        logic signed [15:0]     gain_p;
        logic signed [15:0]     gain_i;
        logic signed [15:0]     gain_d;
        logic signed [8:0]      limit_high;
        logic signed [8:0]      limit_low;
        logic [7:0]             cruise_speed;
        logic [7:0]             max_drive;
    } cfg_t;

    typedef struct packed {
        logic     capture;
        logic     sum;
        logic     div_init;
        logic     div_step;
        logic     integ;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     mul_clear;
        logic     mul_acc;
        logic     drive;
        logic     lost;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic den_zero;
    } dp_stat_t;

endpackage

// File: sv/lfps_ctrl.sv
// lfps_ctrl: sequencing state machine and stream handshake for the steering block.
// Depends on lfps_pkg; drives lfps_dp through dp_cmd_t.
module lfps_ctrl
    import lfps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        cmd.mul_sel = MSEL_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.den_zero) begin
                    state_next = ST_LOST;
                end else begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ  = 1'b1;
                state_next = ST_MUL0;
            end
            ST_MUL0: begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MSEL_P;
                cmd.mul_clear = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_I;
                cmd.mul_acc = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MSEL_D;
                cmd.mul_acc = 1'b1;
                state_next  = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul_acc = 1'b1;
                state_next  = ST_DRIVE;
            end
            ST_DRIVE: begin
                cmd.drive  = 1'b1;
                state_next = ST_DONE;
            end
            ST_LOST: begin
                cmd.lost   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

// File: sv/lfps_dp.sv
// lfps_dp: datapath - centroid sums, serial divider, PID with shared multiplier,
// drive mixing, line search timers and the output register. Depends on lfps_pkg.
module lfps_dp
    import lfps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W        = ((4 * SAMPLE_BITS + 32 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                pid_clear,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [IN_W-1:0]     in_data,
    output logic [OUT_BITS-1:0] out_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int TW   = (SB > THRESH_BITS) ? SB : THRESH_BITS;
    localparam int DENW = SB + 2;
    localparam int NW   = SB + 10;
    localparam int MW   = SB + 9;
    localparam int RW   = DENW + 1;
    localparam int AW   = 36;
    localparam int TDW  = AW + 1;

    // captured beat
    logic [SB-1:0]  samp_reg [4];
    logic [31:0]    now_reg;
    // centroid and divider
    logic [DENW-1:0] den_reg;
    logic [MW-1:0]   mag_reg;
    logic            neg_reg;
    logic [RW-1:0]   rem_reg;
    logic [15:0]     quo_reg;
    // PID
    logic signed [15:0] err_reg;
    logic signed [16:0] integ_reg;
    logic signed [16:0] deriv_reg;
    logic signed [32:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [16:0] integral_sum_reg;
    logic signed [15:0] prev_err_reg;
    // search state
    logic        lost_flag_reg;
    logic [31:0] lost_since_reg;
    logic        search_right_reg;
    logic [31:0] search_phase_reg;
    // result
    logic [7:0]  res_left_reg, res_right_reg;
    drive_mode_t res_mode_reg;
    logic        res_lost_reg;
    logic [15:0] res_err_reg;
    logic [OUT_BITS-1:0] out_reg;

    // ---------------- centroid sums ----------------
    logic [SB-1:0]        ex [4];
    logic signed [NW-1:0] exs [4];
    logic [DENW-1:0]      den_next;
    logic signed [NW-1:0] num_next;
    logic [MW-1:0]        mag_next;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (TW'(samp_reg[i]) > TW'(cfg.detect_threshold))
                ex[i] = SB'(TW'(samp_reg[i]) - TW'(cfg.detect_threshold));
            else
                ex[i] = '0;
            exs[i] = NW'($signed({1'b0, ex[i]}));
        end
        den_next = DENW'(ex[0]) + DENW'(ex[1]) + DENW'(ex[2]) + DENW'(ex[3]);
        num_next = NW'((exs[3] - exs[0]) * 100 + (exs[2] - exs[1]) * 33);
        mag_next = MW'(num_next < 0 ? -num_next : num_next);
    end

    assign stat.den_zero = (den_reg == '0);

    // ---------------- restoring divider, one bit a step ----------------
    logic [RW-1:0] rem_try;
    logic          qbit;

    always_comb begin
        rem_try = {rem_reg[RW-2:0], quo_reg[15]};
        qbit    = (rem_try >= RW'(den_reg));
    end

    // ---------------- integral / derivative ----------------
    logic signed [15:0] err_c;
    logic signed [17:0] isum, ihi, ilo, iclamp;

    always_comb begin
        err_c  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        isum   = 18'(integral_sum_reg) + 18'(err_c);
        ihi    = 18'(cfg.limit_high) <<< 8;
        ilo    = 18'(cfg.limit_low) <<< 8;
        if (isum > ihi)      iclamp = ihi;
        else if (isum < ilo) iclamp = ilo;
        else                 iclamp = isum;
    end

    // ---------------- shared multiplier ----------------
    logic signed [15:0] mul_a;
    logic signed [16:0] mul_b;

    always_comb begin
        case (cmd.mul_sel)
            MSEL_P:  begin mul_a = cfg.gain_p; mul_b = 17'(err_reg); end
            MSEL_I:  begin mul_a = cfg.gain_i; mul_b = integ_reg;    end
            MSEL_D:  begin mul_a = cfg.gain_d; mul_b = deriv_reg;    end
            default: begin mul_a = '0;         mul_b = '0;           end
        endcase
    end

    // ---------------- drive mixing ----------------
    function automatic logic [7:0] drive_of(input logic signed [TDW-1:0] t,
                                            input logic [7:0] top);
        logic signed [TDW-17:0] q;
        begin
            q = (TDW-16)'(t >>> 16);
            if (t < 0 && t[15:0] != '0) q = q + 1'b1;
            if (q > $signed({1'b0, top})) q = (TDW-16)'($signed({1'b0, top}));
            if (q < 0) q = '0;
            drive_of = q[7:0];
        end
    endfunction

    logic signed [AW-1:0]  ahi, alo, corr;
    logic [7:0]            base;
    logic signed [TDW-1:0] base_fx, tl, tr;

    always_comb begin
        ahi = AW'(cfg.limit_high) <<< 16;
        alo = AW'(cfg.limit_low) <<< 16;
        if (acc_reg > ahi)      corr = ahi;
        else if (acc_reg < alo) corr = alo;
        else                    corr = acc_reg;
        if (cfg.cruise_speed > cfg.max_drive)          base = cfg.max_drive;
        else if (cfg.cruise_speed < 8'(MIN_BASE_SPEED)) base = 8'(MIN_BASE_SPEED);
        else                                           base = cfg.cruise_speed;
        base_fx = TDW'($signed({1'b0, base, 16'b0}));
        tl = base_fx - TDW'(corr);
        tr = base_fx + TDW'(corr);
    end

    // ---------------- line search ----------------
    logic [31:0] since_c;
    logic        stop_c, flip_c;

    always_comb begin
        since_c = lost_flag_reg ? lost_since_reg : now_reg;
        stop_c  = (now_reg - since_c) > 32'(LOST_TIMEOUT_MS);
        flip_c  = (now_reg - search_phase_reg) > 32'(SEARCH_FLIP_MS);
    end

    // ---------------- state with reset ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lost_flag_reg    <= 1'b0;
            lost_since_reg   <= '0;
            search_right_reg <= 1'b1;
            search_phase_reg <= '0;
            integral_sum_reg <= '0;
            prev_err_reg     <= '0;
        end else begin
            if (pid_clear) begin
                integral_sum_reg <= '0;
                prev_err_reg     <= '0;
            end else if (cmd.integ) begin
                integral_sum_reg <= iclamp[16:0];
                prev_err_reg     <= err_c;
            end
            if (cmd.integ) lost_flag_reg <= 1'b0;
            if (cmd.lost) begin
                lost_flag_reg  <= 1'b1;
                lost_since_reg <= since_c;
                if (!stop_c && flip_c) begin
                    search_right_reg <= !search_right_reg;
                    search_phase_reg <= now_reg;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < 4; i++) samp_reg[i] <= in_data[i*SB +: SB];
            now_reg <= in_data[4*SB +: 32];
        end
        if (cmd.sum) begin
            den_reg <= den_next;
            mag_reg <= mag_next;
            neg_reg <= (num_next < 0);
        end
        if (cmd.div_init) begin
            rem_reg <= RW'(mag_reg[MW-1:8]);
            quo_reg <= {mag_reg[7:0], 8'b0};
        end else if (cmd.div_step) begin
            rem_reg <= qbit ? rem_try - RW'(den_reg) : rem_try;
            quo_reg <= {quo_reg[14:0], qbit};
        end
        if (cmd.integ) begin
            err_reg   <= err_c;
            integ_reg <= iclamp[16:0];
            deriv_reg <= 17'(err_c) - 17'(prev_err_reg);
        end
        if (cmd.mul_en) prod_reg <= mul_a * mul_b;
        if (cmd.mul_clear)    acc_reg <= '0;
        else if (cmd.mul_acc) acc_reg <= acc_reg + AW'(prod_reg);
        if (cmd.drive) begin
            res_left_reg  <= drive_of(tl, cfg.max_drive);
            res_right_reg <= drive_of(tr, cfg.max_drive);
            res_mode_reg  <= MODE_FOLLOW;
            res_lost_reg  <= 1'b0;
            res_err_reg   <= err_reg;
        end else if (cmd.lost) begin
            res_lost_reg <= 1'b1;
            res_err_reg  <= '0;
            if (stop_c) begin
                res_left_reg  <= '0;
                res_right_reg <= '0;
                res_mode_reg  <= MODE_STOP;
            end else begin
                res_left_reg  <= 8'(SEARCH_SPEED);
                res_right_reg <= 8'(SEARCH_SPEED);
                res_mode_reg  <= (flip_c ? !search_right_reg : search_right_reg)
                                 ? MODE_ROT_RIGHT : MODE_ROT_LEFT;
            end
        end
        if (cmd.out_load)
            out_reg <= OUT_BITS'({res_err_reg, res_lost_reg, res_mode_reg,
                                  res_right_reg, res_left_reg});
    end

    assign out_data = out_reg;

endmodule

// File: sv/line_follow_pid_steering.sv
// line_follow_pid_steering: top level - APB register file, controller and datapath.
// Depends on lfps_pkg, lfps_ctrl and lfps_dp.
//
//   channel  | dir | handshake          | beat contents (low bit first)
//   ---------+-----+--------------------+--------------------------------------------
//   s_       | in  | s_tvalid/s_tready  | 4 samples, now_ms
//   m_       | out | m_tvalid/m_tready  | left, right, mode, lost_line, position_error
//   APB      | in  | psel/penable       | 8 registers at byte address 4*i
//
// Sequence: the accepting edge captures the beat; a beat seen on the line then goes
// through sum, check, 16 divider steps, integral, 4 multiplier slots, mixing and
// load to m_tvalid; a lost-line beat goes through sum, check, search and load. The
// block goes back to idle before it takes the next beat. The divider steps dominate.
// Reset: aresetn, synchronous, active low; control registers reset, payload does not.
// Stalls: s_tready is high only while idle; a finished result waits in its own
// register, so the next beat is taken while m_ holds an untaken one.
module line_follow_pid_steering
    import lfps_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IN_W        = ((4 * SAMPLE_BITS + 32 + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // sense_left, sense_mid_left, sense_mid_right, sense_right, now_ms, zero pad
    input  logic [IN_W-1:0]     s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // left_drive[7:0], right_drive[15:8], drive_mode[17:16], lost_line[18],
    // position_error[34:19], zero pad
    output logic [OUT_BITS-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t     cfg_reg, cfg_next;
    logic     wr_en;
    reg_idx_t wr_idx;
    logic     pid_clear;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_idx_t'(paddr[4:2]);

    always_comb begin
        cfg_next  = cfg_reg;
        pid_clear = 1'b0;
        if (wr_en) begin
            case (wr_idx)
                REG_THRESH:    cfg_next.detect_threshold = pwdata[THRESH_BITS-1:0];
                REG_GAIN_P:    begin cfg_next.gain_p = pwdata[15:0]; pid_clear = 1'b1; end
                REG_GAIN_I:    begin cfg_next.gain_i = pwdata[15:0]; pid_clear = 1'b1; end
                REG_GAIN_D:    begin cfg_next.gain_d = pwdata[15:0]; pid_clear = 1'b1; end
                REG_LIMIT_HI:  cfg_next.limit_high = pwdata[8:0];
                REG_LIMIT_LO:  cfg_next.limit_low = pwdata[8:0];
                REG_CRUISE:    cfg_next.cruise_speed = pwdata[7:0];
                REG_MAX_DRIVE: cfg_next.max_drive = pwdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.detect_threshold <= THRESH_BITS'(512);
            cfg_reg.gain_p           <= 16'sd256;
            cfg_reg.gain_i           <= '0;
            cfg_reg.gain_d           <= '0;
            cfg_reg.limit_high       <= 9'sd100;
            cfg_reg.limit_low        <= -9'sd100;
            cfg_reg.cruise_speed     <= 8'd150;
            cfg_reg.max_drive        <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, signed registers sign-extended
    always_comb begin
        case (reg_idx_t'(paddr[4:2]))
            REG_THRESH:    prdata = 32'(cfg_reg.detect_threshold);
            REG_GAIN_P:    prdata = 32'(cfg_reg.gain_p);
            REG_GAIN_I:    prdata = 32'(cfg_reg.gain_i);
            REG_GAIN_D:    prdata = 32'(cfg_reg.gain_d);
            REG_LIMIT_HI:  prdata = 32'(cfg_reg.limit_high);
            REG_LIMIT_LO:  prdata = 32'(cfg_reg.limit_low);
            REG_CRUISE:    prdata = 32'(cfg_reg.cruise_speed);
            REG_MAX_DRIVE: prdata = 32'(cfg_reg.max_drive);
            default:       prdata = '0;
        endcase
    end

    lfps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfps_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pid_clear (pid_clear),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .out_data  (m_tdata)
    );

endmodule
